// ===== hdl/csdm_pkg.sv =====
// ----------------------------------------------------------------------------
// csdm_pkg
// Shared types, register codes and constants of the column scan depth map.
// ----------------------------------------------------------------------------
package csdm_pkg;

  // Field widths
  localparam int PIX_W      = 9;
  localparam int CH_W       = 8;
  localparam int COL_IN_W   = 10;
  localparam int CROP_W     = 10;
  localparam int THRESH_W   = 10;
  localparam int INV_W      = 24;
  localparam int SCALE_W    = 24;
  localparam int DEPTH_W    = 32;
  localparam int SUM_W      = 10;
  localparam int RAW_ADDR_W = PIX_W + CROP_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_CROP_WIDTH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CROP_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CAMERA_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE      = 3'd4;

  // Register reset values
  localparam logic [CROP_W-1:0]          RST_CROP_WIDTH       = 10'd512;
  localparam logic [THRESH_W-1:0]        RST_WHITE_THRESHOLD  = 10'd384;
  localparam logic [INV_W-1:0]           RST_INV_CROP_WIDTH   = 24'd32768;
  localparam logic [INV_W-1:0]           RST_INV_CAMERA_WIDTH = 24'd16384;
  localparam logic signed [SCALE_W-1:0]  RST_DEPTH_SCALE      = 24'sd256;

  // Operation codes
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  // Parameter defaults
  localparam int DEF_MAX_CROP_WIDTH  = 512;
  localparam int DEF_MAX_CROP_HEIGHT = 512;
  localparam int DEF_COLUMN_BITS     = 10;
  localparam int QUEUE_DEPTH         = 4;

  // Q.32 product to Q16.16
  localparam int FRAC_DROP  = 16;
  localparam int ROUND_BIAS = 32768;

  typedef struct packed {
    logic                op;
    logic [PIX_W-1:0]    pixel_x;
    logic [PIX_W-1:0]    pixel_y;
    logic [CH_W-1:0]     blue;
    logic [CH_W-1:0]     green;
    logic [CH_W-1:0]     red;
    logic [COL_IN_W-1:0] column_index;
  } csdm_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]          out_x;
    logic [PIX_W-1:0]          out_y;
    logic signed [DEPTH_W-1:0] depth;
  } csdm_out_t;

  typedef struct packed {
    logic [CROP_W-1:0]         crop_width;
    logic [THRESH_W-1:0]       white_threshold;
    logic [INV_W-1:0]          inv_crop_width;
    logic [INV_W-1:0]          inv_camera_width;
    logic signed [SCALE_W-1:0] depth_scale;
  } csdm_cfg_t;

  // Command handed from front to back
  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } csdm_cmd_t;

  function automatic int addr_bits(input int depth);
    int bits;
    bits = (depth > 1) ? $clog2(depth) : 1;
    return bits;
  endfunction

endpackage

// ===== hdl/csdm_front.sv =====
// ----------------------------------------------------------------------------
// csdm_front
// Takes input beats, forms the store address, checks crop bounds and the
// lit test, and emits only the commands that touch the store.
// ----------------------------------------------------------------------------
module csdm_front #(
  parameter int MAX_CROP_WIDTH  = csdm_pkg::DEF_MAX_CROP_WIDTH,
  parameter int MAX_CROP_HEIGHT = csdm_pkg::DEF_MAX_CROP_HEIGHT,
  parameter int COLUMN_BITS     = csdm_pkg::DEF_COLUMN_BITS,
  parameter int ADDR_W          = 18
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept_i,
  input  csdm_pkg::csdm_in_t  item_i,
  input  csdm_pkg::csdm_cfg_t cfg_i,
  output logic                push_o,
  output csdm_pkg::csdm_cmd_t cmd_o,
  output logic [ADDR_W-1:0]   addr_o,
  output logic [COLUMN_BITS-1:0] col_o
);
  import csdm_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_CROP_WIDTH * MAX_CROP_HEIGHT;

  logic [RAW_ADDR_W-1:0]  raw_addr;
  logic [SUM_W-1:0]       ch_sum;
  logic                   in_crop;
  logic                   lit;
  logic                   keep;

  logic                   push_r;
  csdm_cmd_t              cmd_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [COLUMN_BITS-1:0] col_r;

  // Address and bounds
  always_comb begin
    raw_addr = RAW_ADDR_W'(item_i.pixel_y) * RAW_ADDR_W'(cfg_i.crop_width)
             + RAW_ADDR_W'(item_i.pixel_x);
    in_crop  = (CROP_W'(item_i.pixel_x) < cfg_i.crop_width)
             && (32'(raw_addr) < STORE_DEPTH);
    ch_sum   = SUM_W'(item_i.blue) + SUM_W'(item_i.green) + SUM_W'(item_i.red);
    lit      = ch_sum > cfg_i.white_threshold;
    keep     = in_crop && ((item_i.op == OP_READOUT) || lit);
  end

  // Command register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_r <= 1'b0;
    end else begin
      push_r <= accept_i && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_i) begin
      cmd_r.op <= item_i.op;
      cmd_r.x  <= item_i.pixel_x;
      cmd_r.y  <= item_i.pixel_y;
      addr_r   <= ADDR_W'(raw_addr);
      col_r    <= COLUMN_BITS'(item_i.column_index);
    end
  end

  assign push_o = push_r;
  assign cmd_o  = cmd_r;
  assign addr_o = addr_r;
  assign col_o  = col_r;

endmodule

// ===== hdl/csdm_queue.sv =====
// ----------------------------------------------------------------------------
// csdm_queue
// Small FIFO between front and back.
// ----------------------------------------------------------------------------
module csdm_queue #(
  parameter int DEPTH  = csdm_pkg::QUEUE_DEPTH,
  parameter int DATA_W = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_i,
  input  logic [DATA_W-1:0]          data_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output logic [DATA_W-1:0]          data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  import csdm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_pop;

  assign do_pop = pop_i && (count_r != '0);

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_i, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wr_ptr_r] <= data_i;
    end
  end

  assign valid_o = (count_r != '0);
  assign data_o  = slot_r[rd_ptr_r];
  assign count_o = count_r;

endmodule

// ===== hdl/csdm_back.sv =====
// ----------------------------------------------------------------------------
// csdm_back
// Owns the column store: clears it after reset, applies captures, reads
// entries for readouts and turns a stored column into a Q16.16 depth.
// ----------------------------------------------------------------------------
module csdm_back #(
  parameter int MAX_CROP_WIDTH  = csdm_pkg::DEF_MAX_CROP_WIDTH,
  parameter int MAX_CROP_HEIGHT = csdm_pkg::DEF_MAX_CROP_HEIGHT,
  parameter int COLUMN_BITS     = csdm_pkg::DEF_COLUMN_BITS,
  parameter int ADDR_W          = 18
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  csdm_pkg::csdm_cfg_t    cfg_i,
  input  logic                   q_valid_i,
  input  csdm_pkg::csdm_cmd_t    q_cmd_i,
  input  logic [ADDR_W-1:0]      q_addr_i,
  input  logic [COLUMN_BITS-1:0] q_col_i,
  output logic                   pop_o,
  output logic                   clr_busy_o,
  output logic                   out_valid_o,
  output csdm_pkg::csdm_out_t    out_item_o
);
  import csdm_pkg::*;

  localparam int STORE_DEPTH = MAX_CROP_WIDTH * MAX_CROP_HEIGHT;
  localparam int ENTRY_W     = COLUMN_BITS + 1;
  localparam int A_W         = PIX_W + INV_W;
  localparam int B_W         = COLUMN_BITS + INV_W;
  localparam int DIFF_W      = ((A_W > B_W) ? A_W : B_W) + 1;
  localparam int PROD_W      = DIFF_W + SCALE_W;
  localparam int RND_W       = PROD_W + 1;
  localparam int Q_W         = RND_W - FRAC_DROP;

  // Store and clearing sweep
  logic [ENTRY_W-1:0] store_r [STORE_DEPTH];
  logic               clr_busy_r;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               rd_en;
  logic [ENTRY_W-1:0] rd_q_r;

  // Depth pipeline
  logic                     s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [PIX_W-1:0]         s1_x_r, s2_x_r, s3_x_r, s4_x_r;
  logic [PIX_W-1:0]         s1_y_r, s2_y_r, s3_y_r, s4_y_r;
  logic [A_W-1:0]           a_r;
  logic [B_W-1:0]           b_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [RND_W-1:0]  rnd;
  logic [Q_W-1:0]           q_val;
  logic [Q_W-32:0]          q_top;
  logic signed [DEPTH_W-1:0] depth_sat;
  logic                     out_valid_r;
  csdm_out_t                out_item_r;

  assign pop_o = q_valid_i && !clr_busy_r;
  assign rd_en = pop_o && (q_cmd_i.op == OP_READOUT);

  // One port: clearing writes, then captures
  always_comb begin
    mem_we    = clr_busy_r || (pop_o && (q_cmd_i.op == OP_CAPTURE));
    mem_waddr = clr_busy_r ? clr_addr_r : q_addr_i;
    mem_wdata = clr_busy_r ? '0 : {1'b1, q_col_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q_r <= store_r[q_addr_i];
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= rd_en;
      s2_v_r      <= s1_v_r && rd_q_r[COLUMN_BITS];
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r;
    end
  end

  // Stage 1: entry read; stage 2: both reciprocal products
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_x_r <= q_cmd_i.x;
      s1_y_r <= q_cmd_i.y;
    end
    a_r    <= A_W'(s1_x_r) * A_W'(cfg_i.inv_crop_width);
    b_r    <= B_W'(rd_q_r[COLUMN_BITS-1:0]) * B_W'(cfg_i.inv_camera_width);
    s2_x_r <= s1_x_r;
    s2_y_r <= s1_y_r;
  end

  // Stage 3: difference; stage 4: scale
  always_ff @(posedge clk) begin
    diff_r <= $signed(DIFF_W'(a_r)) - $signed(DIFF_W'(b_r));
    s3_x_r <= s2_x_r;
    s3_y_r <= s2_y_r;
    prod_r <= PROD_W'(diff_r) * PROD_W'(cfg_i.depth_scale);
    s4_x_r <= s3_x_r;
    s4_y_r <= s3_y_r;
  end

  // Round to nearest (ties up), then saturate to 32 bits
  always_comb begin
    rnd   = $signed({prod_r[PROD_W-1], prod_r}) + $signed(RND_W'(ROUND_BIAS));
    q_val = rnd[RND_W-1:FRAC_DROP];
    q_top = q_val[Q_W-1:31];
    if ((&q_top) || !(|q_top)) begin
      depth_sat = $signed(q_val[DEPTH_W-1:0]);
    end else if (q_val[Q_W-1]) begin
      depth_sat = $signed({1'b1, {(DEPTH_W-1){1'b0}}});
    end else begin
      depth_sat = $signed({1'b0, {(DEPTH_W-1){1'b1}}});
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.out_x <= s4_x_r;
    out_item_r.out_y <= s4_y_r;
    out_item_r.depth <= depth_sat;
  end

  assign clr_busy_o  = clr_busy_r;
  assign out_valid_o = out_valid_r;
  assign out_item_o  = out_item_r;

endmodule

// ===== hdl/column_scan_depth_map_top.sv =====
// ----------------------------------------------------------------------------
// column_scan_depth_map_top
// Readout stages: front, queue, entry read, products, difference, scale, output.
// Throughput: one item per cycle while busy is low; one store access per cycle.
// Reset: the store is swept clear, one entry per cycle, over all
//   MAX_CROP_WIDTH*MAX_CROP_HEIGHT entries (262144 by default) with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module column_scan_depth_map_top #(
  parameter int MAX_CROP_WIDTH  = csdm_pkg::DEF_MAX_CROP_WIDTH,
  parameter int MAX_CROP_HEIGHT = csdm_pkg::DEF_MAX_CROP_HEIGHT,
  parameter int COLUMN_BITS     = csdm_pkg::DEF_COLUMN_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  csdm_pkg::csdm_in_t                in_item,
  output logic                              out_valid,
  output csdm_pkg::csdm_out_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csdm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import csdm_pkg::*;

  localparam int ADDR_W = addr_bits(MAX_CROP_WIDTH * MAX_CROP_HEIGHT);
  localparam int Q_DATA_W = $bits(csdm_cmd_t) + ADDR_W + COLUMN_BITS;
  localparam int Q_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  csdm_cfg_t              cfg_r;
  logic                   accept;
  logic                   f_push;
  csdm_cmd_t              f_cmd;
  logic [ADDR_W-1:0]      f_addr;
  logic [COLUMN_BITS-1:0] f_col;
  logic                   q_valid;
  logic [Q_DATA_W-1:0]    q_data;
  logic [Q_CNT_W-1:0]     q_count;
  csdm_cmd_t              q_cmd;
  logic [ADDR_W-1:0]      q_addr;
  logic [COLUMN_BITS-1:0] q_col;
  logic                   q_pop;
  logic                   clr_busy;

  // Register file, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crop_width       <= RST_CROP_WIDTH;
      cfg_r.white_threshold  <= RST_WHITE_THRESHOLD;
      cfg_r.inv_crop_width   <= RST_INV_CROP_WIDTH;
      cfg_r.inv_camera_width <= RST_INV_CAMERA_WIDTH;
      cfg_r.depth_scale      <= RST_DEPTH_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CROP_WIDTH:       cfg_r.crop_width       <= cfg_data[CROP_W-1:0];
        CFG_WHITE_THRESHOLD:  cfg_r.white_threshold  <= cfg_data[THRESH_W-1:0];
        CFG_INV_CROP_WIDTH:   cfg_r.inv_crop_width   <= cfg_data[INV_W-1:0];
        CFG_INV_CAMERA_WIDTH: cfg_r.inv_camera_width <= cfg_data[INV_W-1:0];
        CFG_DEPTH_SCALE:      cfg_r.depth_scale      <= $signed(cfg_data[SCALE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Hold off while clearing or when the queue holds QUEUE_DEPTH-1 entries or more
  assign busy   = clr_busy || (q_count >= Q_CNT_W'(QUEUE_DEPTH - 1));
  assign accept = start && !busy;

  csdm_front #(
    .MAX_CROP_WIDTH  (MAX_CROP_WIDTH),
    .MAX_CROP_HEIGHT (MAX_CROP_HEIGHT),
    .COLUMN_BITS     (COLUMN_BITS),
    .ADDR_W          (ADDR_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .item_i   (in_item),
    .cfg_i    (cfg_r),
    .push_o   (f_push),
    .cmd_o    (f_cmd),
    .addr_o   (f_addr),
    .col_o    (f_col)
  );

  csdm_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (Q_DATA_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_push),
    .data_i  ({f_cmd, f_addr, f_col}),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data),
    .count_o (q_count)
  );

  assign {q_cmd, q_addr, q_col} = q_data;

  csdm_back #(
    .MAX_CROP_WIDTH  (MAX_CROP_WIDTH),
    .MAX_CROP_HEIGHT (MAX_CROP_HEIGHT),
    .COLUMN_BITS     (COLUMN_BITS),
    .ADDR_W          (ADDR_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_addr_i    (q_addr),
    .q_col_i     (q_col),
    .pop_o       (q_pop),
    .clr_busy_o  (clr_busy),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

endmodule
